FILE: hdl/csl_pkg.sv
package csl_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 3;

   localparam logic [4:0] KIND_LPAREN   = 5'd0;
   localparam logic [4:0] KIND_RPAREN   = 5'd1;
   localparam logic [4:0] KIND_LBRACKET = 5'd2;
   localparam logic [4:0] KIND_RBRACKET = 5'd3;
   localparam logic [4:0] KIND_COLON    = 5'd4;
   localparam logic [4:0] KIND_BAR      = 5'd5;
   localparam logic [4:0] KIND_PIPE     = 5'd6;
   localparam logic [4:0] KIND_ARITH    = 5'd7;
   localparam logic [4:0] KIND_MAPPING  = 5'd8;
   localparam logic [4:0] KIND_COMPARE  = 5'd9;
   localparam logic [4:0] KIND_ASSIGN   = 5'd10;
   localparam logic [4:0] KIND_BOOLOP   = 5'd11;
   localparam logic [4:0] KIND_BOOLLIT  = 5'd12;
   localparam logic [4:0] KIND_PREFIX   = 5'd13;
   localparam logic [4:0] KIND_IDENT    = 5'd14;
   localparam logic [4:0] KIND_NUMBER   = 5'd15;
   localparam logic [4:0] KIND_ERROR    = 5'd16;
   localparam logic [4:0] KIND_END      = 5'd17;

   // pending one-character operator codes
   localparam logic [2:0] PEND_NONE  = 3'd0;
   localparam logic [2:0] PEND_BAR   = 3'd1;
   localparam logic [2:0] PEND_MINUS = 3'd2;
   localparam logic [2:0] PEND_EQ    = 3'd3;
   localparam logic [2:0] PEND_LT    = 3'd4;
   localparam logic [2:0] PEND_GT    = 3'd5;
   localparam logic [2:0] PEND_BANG  = 3'd6;

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_IDENT  = 5'b00010,
      MODE_NUMBER = 5'b00100,
      MODE_PEND   = 5'b01000,
      MODE_ERROR  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0]                   num;
      result_type [MAX_RESULTS-1:0] items;
   } push_type;

   // keyword k character i (and, or, true, false, not)
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
      logic [39:0] w;
      unique case (k)
         3'd0:    w = {"and", 16'h0};
         3'd1:    w = {"or", 24'h0};
         3'd2:    w = {"true", 8'h0};
         3'd3:    w = "false";
         3'd4:    w = {"not", 16'h0};
         default: w = '0;
      endcase
      if (i > 3'd4) begin
         return 8'h00;
      end
      return w[39 - 8 * int'(i) -: 8];
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] k);
      unique case (k)
         3'd0:    return 3'd3;
         3'd1:    return 3'd2;
         3'd2:    return 3'd4;
         3'd3:    return 3'd5;
         3'd4:    return 3'd3;
         default: return 3'd0;
      endcase
   endfunction

   function automatic logic [4:0] kw_kind(input logic [2:0] k);
      unique case (k)
         3'd0, 3'd1: return KIND_BOOLOP;
         3'd2, 3'd3: return KIND_BOOLLIT;
         3'd4:       return KIND_PREFIX;
         default:    return KIND_IDENT;
      endcase
   endfunction

   function automatic logic [2:0] pend_of_char(input logic [7:0] c);
      unique case (c)
         "|":     return PEND_BAR;
         "-":     return PEND_MINUS;
         "=":     return PEND_EQ;
         "<":     return PEND_LT;
         ">":     return PEND_GT;
         "!":     return PEND_BANG;
         default: return PEND_NONE;
      endcase
   endfunction

   function automatic logic [7:0] pend_second(input logic [2:0] p);
      unique case (p)
         PEND_BAR, PEND_MINUS:                    return ">";
         PEND_EQ, PEND_LT, PEND_GT, PEND_BANG:    return "=";
         default:                                 return 8'h00;
      endcase
   endfunction

   function automatic logic [4:0] pend_double(input logic [2:0] p);
      unique case (p)
         PEND_BAR:   return KIND_PIPE;
         PEND_MINUS: return KIND_MAPPING;
         PEND_EQ, PEND_LT, PEND_GT, PEND_BANG: return KIND_COMPARE;
         default:    return KIND_BAR;
      endcase
   endfunction

   function automatic logic [4:0] pend_single(input logic [2:0] p);
      unique case (p)
         PEND_BAR:   return KIND_BAR;
         PEND_MINUS: return KIND_ARITH;
         PEND_EQ:    return KIND_ASSIGN;
         PEND_LT, PEND_GT, PEND_BANG: return KIND_COMPARE;
         default:    return KIND_BAR;
      endcase
   endfunction

endpackage

FILE: hdl/csl_result_queue.sv
module csl_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  csl_pkg::push_type    push,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output csl_pkg::result_type  head,
   output logic [2:0]           free
);
   import csl_pkg::*;

   result_type [QUEUE_DEPTH-1:0] items_ff, items_in;
   logic [2:0] used_ff, used_in;
   logic       pop;
   logic [2:0] after;

   assign rsp_valid = (used_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = items_ff[0];
   // slots available this cycle, counting the one popped
   assign free      = 3'(QUEUE_DEPTH) - used_ff + {2'b00, pop};
   assign after     = used_ff - {2'b00, pop};

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            items_in[i] = items_ff[i + 1];
         end else begin
            items_in[i] = items_ff[i];
         end
         for (int j = 0; j < MAX_RESULTS; j++) begin
            if (3'(j) < {1'b0, push.num} && (after + 3'(j)) == 3'(i)) begin
               items_in[i] = push.items[j];
            end
         end
      end
      used_in = after + {1'b0, push.num};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 3'd0;
      end else begin
         used_ff <= used_in;
      end
      items_ff <= items_in;
   end

endmodule

FILE: hdl/char_stream_lexer.sv
// Streaming maximal-munch tokenizer: one source byte per req item, tokens
// out as (kind, start, length) with run_last marking the final result a
// byte caused. Whitespace (space, tab, newline) is dropped; the byte flagged
// source_end closes any open token, emits an end item (start = source
// length, length = token count) and restarts for a fresh source. An
// unrecognized byte yields an error item and the rest of the source is
// skipped up to its end byte. Each byte is registered, scanned
// combinationally and its 0 to 3 results are written into a 4-entry result
// queue that drives the rsp port. Bytes are taken at one per cycle as long
// as the queue has room for the results the byte produces; the result port
// delivers one item per cycle while rsp_stall is low, so the results of one
// byte leave one after another. A taken byte waits in the input register
// until the queue has room; its results are then registered in the queue
// and the first of them is valid on rsp from there. Positions and run
// lengths saturate at 2^POSITION_BITS - 1; token counts saturate at 65535.
module char_stream_lexer #(
   parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_source_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_run_last
);
   import csl_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_end_ff;

   // scanner state
   mode_type                 mode_ff, mode_in;
   logic [2:0]               pend_ff, pend_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] begin_ff, begin_in;
   logic [POSITION_BITS-1:0] run_ff, run_in;
   logic [15:0]              count_ff, count_in;
   logic [4:0]               mask_ff, mask_in;

   result_type [MAX_RESULTS-1:0] res;
   logic [1:0] res_num;
   logic [2:0] free;
   logic       fire;
   logic       accept;
   push_type   push;
   result_type head;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // drop keywords that cannot match once character c lands at offset run
   function automatic logic [4:0] upd_mask(input logic [4:0] m,
                                           input logic [POSITION_BITS-1:0] run,
                                           input logic [7:0] c);
      logic [4:0] r;
      r = m;
      for (int k = 0; k < 5; k++) begin
         if (run >= POSITION_BITS'(kw_len(3'(k))) || kw_char(3'(k), run[2:0]) != c) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   // token produced when the open ident/number/operator is closed
   function automatic result_type close_item(input mode_type m, input logic [2:0] p,
                                             input logic [POSITION_BITS-1:0] b,
                                             input logic [4:0] mask,
                                             input logic [POSITION_BITS-1:0] run);
      result_type r;
      r.kind   = KIND_IDENT;
      r.start  = 16'(b);
      r.length = 16'(run);
      r.last   = 1'b0;
      if (m == MODE_IDENT) begin
         for (int k = 4; k >= 0; k--) begin
            if (mask[k] && run == POSITION_BITS'(kw_len(3'(k)))) begin
               r.kind = kw_kind(3'(k));
            end
         end
      end else if (m == MODE_NUMBER) begin
         r.kind = KIND_NUMBER;
      end else begin
         r.kind   = pend_single(p);
         r.length = 16'd1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Scan: current state plus registered byte -> results, next state
   // ---------------------------------------------------------------
   always_comb begin
      logic        consumed;
      logic [7:0]  c;
      logic [16:0] cnt_sum;
      result_type  item;

      c         = in_char_ff;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      begin_in  = begin_ff;
      run_in    = run_ff;
      mask_in   = mask_ff;
      res       = '0;
      res_num   = 2'd0;
      consumed  = 1'b0;
      item      = '0;
      cnt_sum   = '0;

      // continue or close the open token
      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
               mask_in  = upd_mask(mask_ff, run_ff, c);
               run_in   = sat_inc(run_ff);
               consumed = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c) || c == ".") begin
               run_in   = sat_inc(run_ff);
               consumed = 1'b1;
            end
         end
         MODE_PEND: begin
            if (pend_ff != PEND_NONE && pend_second(pend_ff) == c) begin
               item.kind   = pend_double(pend_ff);
               item.start  = 16'(begin_ff);
               item.length = 16'd2;
               res[res_num] = item;
               res_num     = res_num + 2'd1;
               pend_in     = PEND_NONE;
               mode_in     = MODE_IDLE;
               consumed    = 1'b1;
            end
         end
         MODE_ERROR: consumed = 1'b1;
         MODE_IDLE:  consumed = 1'b0;
         default:    consumed = 1'b0;
      endcase

      if (!consumed && (mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER ||
                        mode_ff == MODE_PEND)) begin
         res[res_num] = close_item(mode_ff, pend_ff, begin_ff, mask_ff, run_ff);
         res_num      = res_num + 2'd1;
         pend_in      = PEND_NONE;
         mode_in      = MODE_IDLE;
      end

      // start a new token with this byte
      if (!consumed) begin
         item.start  = 16'(pos_ff);
         item.length = 16'd1;
         item.last   = 1'b0;
         priority if (c == " " || c == 8'h09 || c == 8'h0a) begin
            item.kind = KIND_END;
         end else if (c == "(" || c == ")" || c == "[" || c == "]" || c == ":" ||
                      c == "+" || c == "*" || c == "/") begin
            unique case (c)
               "(":     item.kind = KIND_LPAREN;
               ")":     item.kind = KIND_RPAREN;
               "[":     item.kind = KIND_LBRACKET;
               "]":     item.kind = KIND_RBRACKET;
               ":":     item.kind = KIND_COLON;
               default: item.kind = KIND_ARITH;
            endcase
            res[res_num] = item;
            res_num      = res_num + 2'd1;
         end else if (pend_of_char(c) != PEND_NONE) begin
            mode_in  = MODE_PEND;
            pend_in  = pend_of_char(c);
            begin_in = pos_ff;
         end else if (is_alpha(c)) begin
            mode_in  = MODE_IDENT;
            begin_in = pos_ff;
            mask_in  = upd_mask(5'h1f, '0, c);
            run_in   = POSITION_BITS'(1);
         end else if (is_digit(c)) begin
            mode_in  = MODE_NUMBER;
            begin_in = pos_ff;
            run_in   = POSITION_BITS'(1);
         end else begin
            item.kind    = KIND_ERROR;
            res[res_num] = item;
            res_num      = res_num + 2'd1;
            mode_in      = MODE_ERROR;
         end
      end

      // end of source: flush open token, emit end item, restart
      if (in_end_ff) begin
         if (mode_in == MODE_IDENT || mode_in == MODE_NUMBER || mode_in == MODE_PEND) begin
            res[res_num] = close_item(mode_in, pend_in, begin_in, mask_in, run_in);
            res_num      = res_num + 2'd1;
         end
      end

      cnt_sum = {1'b0, count_ff} + {15'd0, res_num};
      count_in = cnt_sum[16] ? 16'hffff : cnt_sum[15:0];

      if (in_end_ff) begin
         item.kind    = KIND_END;
         item.start   = 16'(sat_inc(pos_ff));
         item.length  = count_in;
         item.last    = 1'b0;
         res[res_num] = item;
         res_num      = res_num + 2'd1;
         mode_in      = MODE_IDLE;
         pend_in      = PEND_NONE;
         begin_in     = '0;
         run_in       = '0;
         mask_in      = 5'h1f;
         count_in     = 16'd0;
         pos_in       = '0;
      end else begin
         pos_in = sat_inc(pos_ff);
      end

      if (res_num != 2'd0) begin
         res[res_num - 2'd1].last = 1'b1;
      end
   end

   // a byte moves on once the queue can hold all of its results
   assign fire        = in_valid_ff && ({1'b0, res_num} <= free);
   assign req_stall   = in_valid_ff && !fire;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   assign push.num   = fire ? res_num : 2'd0;
   assign push.items = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         pend_ff     <= PEND_NONE;
         pos_ff      <= '0;
         begin_ff    <= '0;
         run_ff      <= '0;
         count_ff    <= 16'd0;
         mask_ff     <= 5'h1f;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            mode_ff  <= mode_in;
            pend_ff  <= pend_in;
            pos_ff   <= pos_in;
            begin_ff <= begin_in;
            run_ff   <= run_in;
            count_ff <= count_in;
            mask_ff  <= mask_in;
         end
      end
      if (accept) begin
         in_char_ff <= req_char_code;
         in_end_ff  <= req_source_end;
      end
   end

   csl_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .free      (free)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_run_last     = head.last;

endmodule

FILE: tb/tb_char_stream_lexer.sv
`timescale 1ns / 100ps

module tb_char_stream_lexer;
   import csl_pkg::*;

   // receiver hold-off used to back the block up into a req stall
   localparam int LONG_HOLD   = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_source_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_run_last;

   char_stream_lexer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_source_end   (req_source_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_run_last     (rsp_run_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one source byte waiting to be offered on req
   typedef struct {
      logic [7:0] code;
      logic       fin;     // last byte of its source
      logic       drain;   // hold this byte until every expected token is back
   } source_byte_type;

   source_byte_type pending_bytes[$];   // filled by the stimulus block only
   int              next_byte = 0;      // driver's read index into pending_bytes
   logic [7:0]      src_text[$];        // source under construction

   result_type   expected_tokens[$]; // tokens the lexer model says are due, oldest first

   // handshake counts, each written by one process and tracked by another
   int bytes_taken = 0;
   int bytes_retired = 0;
   int tokens_taken = 0;
   int tokens_retired = 0;

   // pacing, set by the stimulus block per phase
   int send_gap_max = 5;
   int take_stall_max = 5;
   int hold_orders = 0;
   int holds_served = 0;

   int send_wait = 0;
   int take_wait = 0;
   int hold_left = 0;
   int mismatches = 0;

   string      kw_name[5]  = '{"and", "or", "true", "false", "not"};
   logic [4:0] kw_class[5] = '{KIND_BOOLOP, KIND_BOOLOP, KIND_BOOLLIT, KIND_BOOLLIT,
                               KIND_PREFIX};
   string      op_pairs[6] = '{"|>", "->", "==", "<=", ">=", "!="};

   // ------------------------------------------------------------------
   // Lexer model state
   // ------------------------------------------------------------------
   mode_type    lex_mode;
   logic [7:0]  lex_op;      // first char of a pending operator
   logic [15:0] lex_pos;     // offset of the next byte
   logic [15:0] lex_begin;   // offset of the open token
   logic [15:0] lex_count;   // tokens emitted in this source, end token excluded
   logic [15:0] lex_run;     // length of the open identifier or number
   logic [4:0]  lex_mask;    // keywords still matching the open identifier

   function automatic logic [15:0] sat_up(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [4:0] lone_op_kind(input logic [7:0] c);
      case (c)
         "|":     return KIND_BAR;
         "-":     return KIND_ARITH;
         "=":     return KIND_ASSIGN;
         default: return KIND_COMPARE;   // < > !
      endcase
   endfunction

   function void lex_clear();
      lex_mode  = MODE_IDLE;
      lex_op    = 8'h00;
      lex_pos   = '0;
      lex_begin = '0;
      lex_count = '0;
      lex_run   = '0;
      lex_mask  = '1;
   endfunction

   function void add_token(input logic [4:0] kind, input logic [15:0] start,
                           input logic [15:0] len);
      result_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = len;
      t.last   = 1'b0;
      expected_tokens = {expected_tokens, t};
      if (kind != KIND_END) begin
         lex_count = sat_up(lex_count);
      end
   endfunction

   // drop keywords that no longer match with c at the current run offset
   function void track_keyword(input logic [7:0] c);
      for (int k = 0; k < 5; k++) begin
         if (int'(lex_run) >= kw_name[k].len() || kw_name[k][int'(lex_run)] != c) begin
            lex_mask[k] = 1'b0;
         end
      end
   endfunction

   function void close_token();
      logic [4:0] kind;
      case (lex_mode)
         MODE_IDENT: begin
            kind = KIND_IDENT;
            for (int k = 4; k >= 0; k--) begin
               if (lex_mask[k] && int'(lex_run) == kw_name[k].len()) begin
                  kind = kw_class[k];
               end
            end
            add_token(kind, lex_begin, lex_run);
         end
         MODE_NUMBER: add_token(KIND_NUMBER, lex_begin, lex_run);
         MODE_PEND: begin
            add_token(lone_op_kind(lex_op), lex_begin, 16'd1);
            lex_op = 8'h00;
         end
         default: ;
      endcase
      if (lex_mode != MODE_ERROR) begin
         lex_mode = MODE_IDLE;
      end
   endfunction

   // byte seen with nothing open
   function void open_byte(input logic [7:0] c, input logic [15:0] pos);
      case (c)
         " ", "\t", "\n": ;
         "(":           add_token(KIND_LPAREN, pos, 16'd1);
         ")":           add_token(KIND_RPAREN, pos, 16'd1);
         "[":           add_token(KIND_LBRACKET, pos, 16'd1);
         "]":           add_token(KIND_RBRACKET, pos, 16'd1);
         ":":           add_token(KIND_COLON, pos, 16'd1);
         "+", "*", "/": add_token(KIND_ARITH, pos, 16'd1);
         "|", "-", "=", "<", ">", "!": begin
            lex_mode  = MODE_PEND;
            lex_op    = c;
            lex_begin = pos;
         end
         default: begin
            if (is_letter(c)) begin
               lex_mode  = MODE_IDENT;
               lex_begin = pos;
               lex_mask  = '1;
               lex_run   = '0;
               track_keyword(c);
               lex_run   = 16'd1;
            end else if (is_digit(c)) begin
               lex_mode  = MODE_NUMBER;
               lex_begin = pos;
               lex_run   = 16'd1;
            end else begin
               add_token(KIND_ERROR, pos, 16'd1);
               lex_mode = MODE_ERROR;
            end
         end
      endcase
   endfunction

   // advance the model by one accepted byte, queueing the tokens it causes
   function void lex_byte(input logic [7:0] c, input logic fin);
      logic [15:0] pos;
      logic        used;
      int          first;
      pos   = lex_pos;
      used  = 1'b0;
      first = expected_tokens.size();
      case (lex_mode)
         MODE_IDENT: begin
            if (is_letter(c) || is_digit(c)) begin
               track_keyword(c);
               lex_run = sat_up(lex_run);
               used    = 1'b1;
            end else begin
               close_token();
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c) || c == ".") begin
               lex_run = sat_up(lex_run);
               used    = 1'b1;
            end else begin
               close_token();
            end
         end
         MODE_PEND: begin
            // two-char operators: |> -> and any of = < > ! followed by =
            if (c == ">" && (lex_op == "|" || lex_op == "-")) begin
               add_token((lex_op == "|") ? KIND_PIPE : KIND_MAPPING, lex_begin, 16'd2);
               used = 1'b1;
            end else if (c == "=" && lex_op != "|" && lex_op != "-") begin
               add_token(KIND_COMPARE, lex_begin, 16'd2);
               used = 1'b1;
            end
            if (used) begin
               lex_op   = 8'h00;
               lex_mode = MODE_IDLE;
            end else begin
               close_token();
            end
         end
         MODE_ERROR: used = 1'b1;   // skip until the source ends
         default: ;
      endcase
      if (!used) begin
         open_byte(c, pos);
      end
      if (fin) begin
         close_token();
         add_token(KIND_END, sat_up(pos), lex_count);
         lex_clear();
      end else begin
         lex_pos = sat_up(lex_pos);
      end
      if (expected_tokens.size() > first) begin
         expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("%0t: token mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Output check first, then the input side: a token leaving at this edge
   // can only come from a byte taken at an earlier edge.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         lex_clear();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            tokens_taken++;
            if (expected_tokens.size() == 0) begin
               report_mismatch("unexpected token kind", rsp_token_kind, -1);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_token_kind !== want.kind) begin
                  report_mismatch("kind", rsp_token_kind, want.kind);
               end
               if (rsp_token_start !== want.start) begin
                  report_mismatch("start", rsp_token_start, want.start);
               end
               if (rsp_token_length !== want.length) begin
                  report_mismatch("length", rsp_token_length, want.length);
               end
               if (rsp_run_last !== want.last) begin
                  report_mismatch("run_last", rsp_run_last, want.last);
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            lex_byte(req_char_code, req_source_end);
         end
      end
   end

   // ------------------------------------------------------------------
   // Byte driver: a random gap after each accepted item, a drain marker
   // holds its byte back until the result side has caught up.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      logic offer;
      offer = req_valid;
      if (bytes_taken != bytes_retired) begin
         bytes_retired = bytes_taken;
         offer         = 1'b0;
         send_wait     = $urandom_range(0, send_gap_max);
      end
      if (!offer && !reset) begin
         if (send_wait > 0) begin
            send_wait--;
         end else if (next_byte < pending_bytes.size()) begin
            if (!(pending_bytes[next_byte].drain && expected_tokens.size() != 0)) begin
               req_char_code  <= pending_bytes[next_byte].code;
               req_source_end <= pending_bytes[next_byte].fin;
               next_byte++;
               offer = 1'b1;
            end
         end
      end
      req_valid <= offer;
   end

   // ------------------------------------------------------------------
   // Token receiver: random stall after each item, plus an ordered long hold
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      logic hold;
      if (hold_orders != holds_served) begin
         holds_served = hold_orders;
         hold_left    = LONG_HOLD;
      end
      if (tokens_taken != tokens_retired) begin
         tokens_retired = tokens_taken;
         take_wait      = $urandom_range(0, take_stall_max);
      end
      if (hold_left > 0) begin
         hold_left--;
         hold = 1'b1;
      end else if (take_wait > 0) begin
         take_wait--;
         hold = 1'b1;
      end else begin
         hold = 1'b0;
      end
      rsp_stall <= hold;
   end

   // ------------------------------------------------------------------
   // Source text builders
   // ------------------------------------------------------------------
   function automatic logic [7:0] pick_char(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   task automatic add_char(input logic [7:0] c);
      src_text = {src_text, c};
   endtask

   task automatic add_word(input string w);
      for (int i = 0; i < w.len(); i++) begin
         add_char(w[i]);
      end
   endtask

   task automatic queue_text(input bit drain_first);
      source_byte_type b;
      foreach (src_text[i]) begin
         b.code  = src_text[i];
         b.fin   = (i == src_text.size() - 1);
         b.drain = drain_first && (i == 0);
         pending_bytes = {pending_bytes, b};
      end
      src_text.delete();
   endtask

   task automatic add_random_lexeme();
      int k;
      int n;
      case ($urandom_range(0, 15))
         0, 1:  add_char(pick_char("()[]:+*/"));
         2, 3:  add_word(op_pairs[$urandom_range(0, 5)]);
         4, 13: add_char(pick_char("|-=<>!"));
         5, 6: begin
            // keyword, sometimes with a tail that turns it into an identifier
            k = $urandom_range(0, 4);
            add_word(kw_name[k]);
            if ($urandom_range(0, 3) == 0) begin
               add_char(pick_char("_aez0129"));
            end
         end
         7: begin
            // keyword cut one short
            k = $urandom_range(0, 4);
            for (int i = 0; i < kw_name[k].len() - 1; i++) begin
               add_char(kw_name[k][i]);
            end
         end
         8, 9, 10: begin
            add_char(pick_char("_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
               add_char(pick_char("_azAZgnqt0189"));
            end
         end
         11, 12, 14: begin
            add_char(pick_char("0123456789"));
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
               add_char(pick_char("0123456789."));
            end
         end
         default: add_char(8'($urandom_range(0, 255)));   // noise
      endcase
   endtask

   task automatic queue_random_source(input bit drain_first);
      int ntok;
      ntok = $urandom_range(1, 6);
      for (int t = 0; t < ntok; t++) begin
         case ($urandom_range(0, 3))
            2:       add_char(" ");
            3:       add_char(pick_char(" \t\n"));
            default: ;   // glued to the previous lexeme
         endcase
         add_random_lexeme();
      end
      queue_text(drain_first);
   endtask

   task automatic wait_all_sent();
      while (next_byte < pending_bytes.size() || req_valid) begin
         @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int base;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: brackets, colon, slash, pipe, greater-or-equal, number open at end
      add_word("([]):/|>");
      queue_text(1'b0);
      add_word("not x>=9.");
      queue_text(1'b0);
      // keywords, whitespace, error then bytes skipped up to the end byte
      add_word("or\tfalse\nand");
      add_char(8'h00);
      add_char(8'hFF);
      queue_text(1'b0);
      // lone operator still pending at the end byte
      add_word("=");
      queue_text(1'b0);
      wait_all_sent();

      // random sources in segments with different pacing
      for (int seg = 0; seg < 5; seg++) begin
         case (seg)
            0: begin send_gap_max = 5; take_stall_max = 5; end
            1: begin send_gap_max = 0; take_stall_max = 0; end
            2: begin
               // sender runs flat out while the receiver holds off
               send_gap_max   = 0;
               take_stall_max = 2;
               hold_orders++;
            end
            3: begin send_gap_max = 3; take_stall_max = 0; end
            default: begin send_gap_max = 0; take_stall_max = 5; end
         endcase
         base = pending_bytes.size();
         // segment 3 opens only after every expected token has come back
         queue_random_source(seg == 3);
         while (pending_bytes.size() - base < 12) begin
            queue_random_source(1'b0);
         end
         wait_all_sent();
      end

      while (expected_tokens.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
hdl/csl_pkg.sv
hdl/csl_result_queue.sv
hdl/char_stream_lexer.sv
tb/tb_char_stream_lexer.sv
